// ----- sv/cdsd_pkg.sv -----
// shared constants and types for the cd sector directory record parser
// used by every module of the block; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none
package cdsd_pkg;

   localparam int RAW_SECTOR_BYTES = 2352;
   localparam int USER_DATA_BYTES  = 2048;

   localparam int POS_W    = $clog2(RAW_SECTOR_BYTES + 1);
   localparam int U_W      = $clog2(USER_DATA_BYTES);
   localparam int OFFSET_W = 11;

   localparam logic [POS_W-1:0] RAW_LIMIT  = POS_W'(RAW_SECTOR_BYTES);
   localparam logic [POS_W-1:0] USER_LIMIT = POS_W'(USER_DATA_BYTES);
   localparam logic [U_W:0]     REC_LIMIT  = (U_W + 1)'(USER_DATA_BYTES);

   localparam logic [POS_W-1:0] MODE_BYTE_POS   = POS_W'(15);
   localparam logic [7:0]       MODE_TWO        = 8'h02;
   localparam logic [POS_W-1:0] MODE2_DATA_POS  = POS_W'(24);
   localparam logic [POS_W-1:0] OTHER_DATA_POS  = POS_W'(16);

   // record byte offsets
   localparam logic [7:0] REC_ADDR_B0  = 8'd2;
   localparam logic [7:0] REC_ADDR_B1  = 8'd3;
   localparam logic [7:0] REC_ADDR_B2  = 8'd4;
   localparam logic [7:0] REC_ADDR_B3  = 8'd5;
   localparam logic [7:0] REC_SIZE_B0  = 8'd10;
   localparam logic [7:0] REC_SIZE_B1  = 8'd11;
   localparam logic [7:0] REC_SIZE_B2  = 8'd12;
   localparam logic [7:0] REC_SIZE_B3  = 8'd13;
   localparam logic [7:0] REC_FLAGS    = 8'd25;
   localparam logic [7:0] REC_NAME_LEN = 8'd32;
   localparam logic [7:0] REC_NAME_B0  = 8'd33;

   localparam logic [1:0] KIND_ORDINARY = 2'd0;
   localparam logic [1:0] KIND_CURRENT  = 2'd1;
   localparam logic [1:0] KIND_PARENT   = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // word passed from the front to the back
   typedef struct packed {
      logic           first;
      logic           user;
      logic [U_W-1:0] offset;
      logic [7:0]     data;
   } item_type;

   typedef struct packed {
      logic [31:0]         extent_address;
      logic [31:0]         data_length;
      logic                is_directory;
      logic [7:0]          name_length;
      logic [1:0]          name_kind;
      logic [OFFSET_W-1:0] record_offset;
   } result_type;

endpackage
`default_nettype wire

// ----- sv/cdsd_front.sv -----
// front end: tracks position and sector mode, classifies each raw byte
// depends on cdsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module cdsd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [7:0]        in_data,
   input  wire logic              in_first,
   output logic                   in_ready,
   output logic                   out_valid,
   output cdsd_pkg::item_type     out_item,
   input  wire logic              out_ready
);

   logic [cdsd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 mode_ff, mode_in;
   logic [cdsd_pkg::POS_W-1:0] p;
   logic [cdsd_pkg::POS_W-1:0] data_pos;
   logic [cdsd_pkg::POS_W-1:0] u;
   logic                       in_range;
   logic                       user;
   logic                       accept;

   assign in_ready = out_ready;
   assign accept   = in_valid && out_ready;

   always_comb begin
      p        = in_first ? '0 : pos_ff;
      in_range = p < cdsd_pkg::RAW_LIMIT;
      mode_in  = mode_ff;
      pos_in   = p;
      if (in_range) begin
         pos_in = p + 1'b1;
         if (p == cdsd_pkg::MODE_BYTE_POS) begin
            mode_in = in_data;
         end
      end
      data_pos = (mode_in == cdsd_pkg::MODE_TWO) ? cdsd_pkg::MODE2_DATA_POS
                                                 : cdsd_pkg::OTHER_DATA_POS;
      u        = p - data_pos;
      user     = in_range && (p >= data_pos) && (u < cdsd_pkg::USER_LIMIT);
   end

   // only sector starts and user-data bytes matter to the walker
   assign out_valid       = in_valid && (in_first || user);
   assign out_item.first  = in_first;
   assign out_item.user   = user;
   assign out_item.offset = u[cdsd_pkg::U_W-1:0];
   assign out_item.data   = in_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mode_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         mode_ff <= mode_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/cdsd_queue.sv -----
// short queue of classified words between front and back
// depends on cdsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module cdsd_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  cdsd_pkg::item_type in_item,
   output logic               in_ready,
   output logic               out_valid,
   output cdsd_pkg::item_type out_item,
   input  wire logic          out_ready
);

   cdsd_pkg::item_type          mem_ff [cdsd_pkg::QUEUE_DEPTH];
   logic [cdsd_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [cdsd_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        push, pop;

   assign in_ready  = cnt_ff != cdsd_pkg::QCNT_W'(cdsd_pkg::QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/cdsd_back.sv -----
// back end: walks directory records and holds the result output register
// depends on cdsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module cdsd_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  cdsd_pkg::item_type  in_item,
   output logic                in_ready,
   output logic                out_valid,
   output cdsd_pkg::result_type out_result,
   input  wire logic           out_ready
);

   logic [cdsd_pkg::U_W-1:0] start_ff, start_in;
   logic [7:0]               len_ff, len_in;
   logic                     stopped_ff, stopped_in;
   logic [31:0]              addr_ff, addr_in;
   logic [31:0]              size_ff, size_in;
   logic [7:0]               flags_ff, flags_in;
   logic [7:0]               nlen_ff, nlen_in;
   logic [7:0]               nbyte_ff, nbyte_in;
   logic                     valid_ff, valid_in;
   cdsd_pkg::result_type     result_ff, result_in;

   logic                     pop;
   logic                     active;
   logic                     emit;
   logic [cdsd_pkg::U_W-1:0] diff;
   logic [7:0]               r;
   logic [cdsd_pkg::U_W:0]   rec_end;
   logic [1:0]               kind;

   assign in_ready   = !valid_ff || out_ready;
   assign pop        = in_valid && in_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      start_in   = start_ff;
      len_in     = len_ff;
      stopped_in = stopped_ff;
      addr_in    = addr_ff;
      size_in    = size_ff;
      flags_in   = flags_ff;
      nlen_in    = nlen_ff;
      nbyte_in   = nbyte_ff;
      active     = 1'b0;
      emit       = 1'b0;
      diff       = '0;
      r          = '0;
      rec_end    = '0;
      kind       = cdsd_pkg::KIND_ORDINARY;

      if (pop) begin
         if (in_item.first) begin
            start_in   = '0;
            len_in     = '0;
            stopped_in = 1'b0;
            addr_in    = '0;
            size_in    = '0;
            flags_in   = '0;
            nlen_in    = '0;
            nbyte_in   = '0;
         end
         if (in_item.user && !stopped_in) begin
            if (len_in == '0) begin
               if (in_item.offset == start_in) begin
                  rec_end = {1'b0, start_in} + (cdsd_pkg::U_W + 1)'(in_item.data);
                  if (in_item.data == '0 || rec_end > cdsd_pkg::REC_LIMIT) begin
                     stopped_in = 1'b1;
                  end else begin
                     len_in   = in_item.data;
                     addr_in  = '0;
                     size_in  = '0;
                     flags_in = '0;
                     nlen_in  = '0;
                     nbyte_in = '0;
                     active   = 1'b1;
                  end
               end
            end else begin
               active = in_item.offset >= start_in;
            end
         end
         diff = in_item.offset - start_in;
         if (active && (diff < cdsd_pkg::U_W'(len_in))) begin
            r = diff[7:0];
            case (r)
               cdsd_pkg::REC_ADDR_B0:  addr_in[7:0]   = in_item.data;
               cdsd_pkg::REC_ADDR_B1:  addr_in[15:8]  = in_item.data;
               cdsd_pkg::REC_ADDR_B2:  addr_in[23:16] = in_item.data;
               cdsd_pkg::REC_ADDR_B3:  addr_in[31:24] = in_item.data;
               cdsd_pkg::REC_SIZE_B0:  size_in[7:0]   = in_item.data;
               cdsd_pkg::REC_SIZE_B1:  size_in[15:8]  = in_item.data;
               cdsd_pkg::REC_SIZE_B2:  size_in[23:16] = in_item.data;
               cdsd_pkg::REC_SIZE_B3:  size_in[31:24] = in_item.data;
               cdsd_pkg::REC_FLAGS:    flags_in       = in_item.data;
               cdsd_pkg::REC_NAME_LEN: nlen_in        = in_item.data;
               cdsd_pkg::REC_NAME_B0:  nbyte_in       = in_item.data;
               default: ;
            endcase
            if (r == len_in - 1'b1) begin
               emit = 1'b1;
               if (nlen_in == 8'd1 && nbyte_in == 8'd0) begin
                  kind = cdsd_pkg::KIND_CURRENT;
               end else if (nlen_in == 8'd1 && nbyte_in == 8'd1) begin
                  kind = cdsd_pkg::KIND_PARENT;
               end
               rec_end = {1'b0, start_in} + (cdsd_pkg::U_W + 1)'(len_in);
               len_in  = '0;
               if (rec_end >= cdsd_pkg::REC_LIMIT) begin
                  stopped_in = 1'b1;
               end else begin
                  start_in = rec_end[cdsd_pkg::U_W-1:0];
               end
            end
         end
      end

      result_in.extent_address = addr_in;
      result_in.data_length    = size_in;
      result_in.is_directory   = flags_in[1];
      result_in.name_length    = nlen_in;
      result_in.name_kind      = kind;
      result_in.record_offset  = cdsd_pkg::OFFSET_W'(
                                    {1'b0, in_item.offset - diff});

      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   // result payload only loads when a record completes
   always_ff @(posedge clock) begin
      if (emit) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         len_ff     <= '0;
         stopped_ff <= 1'b1;
         addr_ff    <= '0;
         size_ff    <= '0;
         flags_ff   <= '0;
         nlen_ff    <= '0;
         nbyte_ff   <= '0;
         valid_ff   <= 1'b0;
      end else begin
         start_ff   <= start_in;
         len_ff     <= len_in;
         stopped_ff <= stopped_in;
         addr_ff    <= addr_in;
         size_ff    <= size_in;
         flags_ff   <= flags_in;
         nlen_ff    <= nlen_in;
         nbyte_ff   <= nbyte_in;
         valid_ff   <= valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/cd_sector_directory_record_parser.sv -----
// cd sector directory record parser: one raw sector byte per cycle in while results
// are taken, one result word per complete directory record out
// throughput one byte per cycle while rsp_ready keeps up; after a record's last byte is
// accepted, its result passes the classification queue, then the output register
// a two-word queue lets the front keep taking bytes while a result waits
// synchronous active-high reset; no record is parsed until the first sector start
`timescale 1ns / 1ps
`default_nettype none
module cd_sector_directory_record_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_raw_byte,
   input  wire logic        req_sector_first,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_extent_address,
   output logic [31:0]      rsp_data_length,
   output logic             rsp_is_directory,
   output logic [7:0]       rsp_name_length,
   output logic [1:0]       rsp_name_kind,
   output logic [10:0]      rsp_record_offset
);

   cdsd_pkg::item_type   front_item, back_item;
   logic                 front_valid, front_ready;
   logic                 back_valid, back_ready;
   cdsd_pkg::result_type result;

   cdsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_raw_byte),
      .in_first  (req_sector_first),
      .in_ready  (req_ready),
      .out_valid (front_valid),
      .out_item  (front_item),
      .out_ready (front_ready)
   );

   cdsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_item  (back_item),
      .out_ready (back_ready)
   );

   cdsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (back_valid),
      .in_item    (back_item),
      .in_ready   (back_ready),
      .out_valid  (rsp_valid),
      .out_result (result),
      .out_ready  (rsp_ready)
   );

   assign rsp_extent_address = result.extent_address;
   assign rsp_data_length    = result.data_length;
   assign rsp_is_directory   = result.is_directory;
   assign rsp_name_length    = result.name_length;
   assign rsp_name_kind      = result.name_kind;
   assign rsp_record_offset  = result.record_offset;

`ifndef NO_ASSERTIONS
   // dot markers only come from one-byte identifiers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_name_kind != cdsd_pkg::KIND_ORDINARY |-> rsp_name_length == 8'd1)
      else $error("dot marker on a name longer than one byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_name_kind <= cdsd_pkg::KIND_PARENT)
      else $error("undefined name kind");

   // the back drains the queue whenever its output register can take a word
   assert property (@(posedge clock) disable iff (reset)
      back_valid && (!rsp_valid || rsp_ready) |-> back_ready)
      else $error("back stalled with free output register");

   // no byte is lost: an empty queue always admits the front
   assert property (@(posedge clock) disable iff (reset)
      !back_valid |-> req_ready)
      else $error("input stalled with empty queue");
`endif

endmodule
`default_nettype wire
